[sv/cfsp_pkg.sv]
// Package with the phase codes, token kinds, error codes and payload types of the parser.
`default_nettype none
package cfsp_pkg;

  localparam logic [31:0] CLASS_MAGIC = 32'hCAFEBABE;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_POOLCOUNT, PH_TAG, PH_OPERAND, PH_UTF8LEN,
    PH_UTF8BYTE, PH_ACCESS, PH_THIS, PH_SUPER, PH_IFCOUNT, PH_IFACE, PH_FIELDSCOUNT,
    PH_MACCESS, PH_MNAME, PH_MDESC, PH_MATTRCOUNT, PH_METHODSCOUNT, PH_ATTRNAME,
    PH_ATTRLEN, PH_ATTRBYTE, PH_CLASSATTRCOUNT, PH_CANAME, PH_CALEN, PH_CABYTE, PH_DONE
  } phase_t;

  localparam logic [4:0] TK_MAGIC = 5'd0;
  localparam logic [4:0] TK_MINOR = 5'd1;
  localparam logic [4:0] TK_MAJOR = 5'd2;
  localparam logic [4:0] TK_POOLCOUNT = 5'd3;
  localparam logic [4:0] TK_TAG = 5'd4;
  localparam logic [4:0] TK_U2 = 5'd5;
  localparam logic [4:0] TK_U4 = 5'd6;
  localparam logic [4:0] TK_UTF8LEN = 5'd7;
  localparam logic [4:0] TK_UTF8BYTE = 5'd8;
  localparam logic [4:0] TK_ACCESS = 5'd9;
  localparam logic [4:0] TK_THIS = 5'd10;
  localparam logic [4:0] TK_SUPER = 5'd11;
  localparam logic [4:0] TK_IFCOUNT = 5'd12;
  localparam logic [4:0] TK_IFACE = 5'd13;
  localparam logic [4:0] TK_FIELDSCOUNT = 5'd14;
  localparam logic [4:0] TK_MACCESS = 5'd15;
  localparam logic [4:0] TK_MNAME = 5'd16;
  localparam logic [4:0] TK_MDESC = 5'd17;
  localparam logic [4:0] TK_MATTRCOUNT = 5'd18;
  localparam logic [4:0] TK_METHODSCOUNT = 5'd19;
  localparam logic [4:0] TK_ATTRNAME = 5'd20;
  localparam logic [4:0] TK_ATTRLEN = 5'd21;
  localparam logic [4:0] TK_ATTRBYTE = 5'd22;
  localparam logic [4:0] TK_CLASSATTRCOUNT = 5'd23;
  localparam logic [4:0] TK_END = 5'd24;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_TAG = 2'd2;

  localparam logic [3:0] TAG_UTF8 = 4'd1;
  localparam logic [3:0] TAG_INTEGER = 4'd3;
  localparam logic [3:0] TAG_FLOAT = 4'd4;
  localparam logic [3:0] TAG_LONG = 4'd5;
  localparam logic [3:0] TAG_DOUBLE = 4'd6;
  localparam logic [3:0] TAG_METHODREF_FIRST = 4'd9;
  localparam logic [3:0] TAG_NAMEANDTYPE = 4'd12;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] token_value;
    logic [15:0] pool_slot;
    logic [1:0]  error_code;
  } out_item_t;

endpackage
`default_nettype wire

[sv/cfsp_core.sv]
// Parser state and the per-byte token logic, with a registered result stage.
`default_nettype none
module cfsp_core
  import cfsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_valid,
  input  in_item_t       item,
  output logic           item_ready,
  output logic           res_valid,
  output out_item_t      res,
  input  wire logic      res_ready
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  nbytes_r, nbytes_nxt;
  logic [3:0]  tag_r, tag_nxt;
  logic [1:0]  opstep_r, opstep_nxt;
  logic [15:0] ptotal_r, ptotal_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [15:0] items_r, items_nxt;
  logic [15:0] attrs_r, attrs_nxt;
  logic [31:0] pay_r, pay_nxt;
  logic        inmeth_r, inmeth_nxt;
  logic        stop_r, stop_nxt;
  logic        vld_r;
  out_item_t   res_r;

  logic        emit;
  out_item_t   tok;
  logic        take;

  assign item_ready = !vld_r || res_ready;
  assign take = item_valid && item_ready;
  assign res_valid = vld_r;
  assign res = res_r;

  always_comb begin
    phase_t      ph;
    logic [31:0] a;
    logic [2:0]  nb;
    logic [3:0]  tg;
    logic [1:0]  os;
    logic [15:0] pt, pi, it, at;
    logic [31:0] py;
    logic        im, st;
    logic [2:0]  need;
    logic [31:0] v;
    logic [31:0] acc_sh;
    logic        wide, dbl;
    logic [15:0] pi_fin, it_dec, at_dec;
    logic [31:0] py_dec;
    phase_t      fin_ph, mdone_ph, after_ph;
    ph = phase_r; a = acc_r; nb = nbytes_r; tg = tag_r; os = opstep_r;
    pt = ptotal_r; pi = pidx_r; it = items_r; at = attrs_r; py = pay_r;
    im = inmeth_r; st = stop_r;
    if (item.start_of_file) begin
      ph = PH_MAGIC; a = '0; nb = '0; tg = '0; os = '0; pt = '0; pi = '0;
      it = '0; at = '0; py = '0; im = 1'b0; st = 1'b0;
    end
    phase_nxt = ph; acc_nxt = a; nbytes_nxt = nb; tag_nxt = tg; opstep_nxt = os;
    ptotal_nxt = pt; pidx_nxt = pi; items_nxt = it; attrs_nxt = at; pay_nxt = py;
    inmeth_nxt = im; stop_nxt = st;
    emit = 1'b0;
    tok = '0;
    wide = (tg == TAG_INTEGER) || (tg == TAG_FLOAT) || (tg == TAG_LONG) || (tg == TAG_DOUBLE);
    dbl = (tg == TAG_LONG) || (tg == TAG_DOUBLE);
    case (ph)
      PH_MAGIC, PH_ATTRLEN, PH_CALEN: need = 3'd4;
      PH_OPERAND: need = wide ? 3'd4 : 3'd2;
      PH_TAG, PH_UTF8BYTE, PH_ATTRBYTE, PH_CABYTE, PH_DONE: need = 3'd1;
      default: need = 3'd2;
    endcase
    acc_sh = {a[23:0], item.data_byte};
    v = (need > 3'd1) ? acc_sh : {24'd0, item.data_byte};
    pi_fin = pi + (dbl ? 16'd2 : 16'd1);
    fin_ph = ({1'b0, pi_fin} + 17'd1 < {1'b0, pt}) ? PH_TAG : PH_ACCESS;
    it_dec = it - 16'd1;
    at_dec = at - 16'd1;
    py_dec = py - 32'd1;
    after_ph = im ? PH_CLASSATTRCOUNT : PH_METHODSCOUNT;
    mdone_ph = (it_dec != 16'd0) ? PH_MACCESS : after_ph;
    if (!st) begin
      if (need > 3'd1 && (nb + 3'd1) < need) begin
        acc_nxt = acc_sh;
        nbytes_nxt = nb + 3'd1;
      end else begin
        acc_nxt = '0;
        nbytes_nxt = '0;
        emit = 1'b1;
        tok.token_value = v;
        case (ph)
          PH_MAGIC: begin
            tok.token_kind = TK_MAGIC;
            if (v != CLASS_MAGIC) begin
              stop_nxt = 1'b1;
              tok.error_code = ERR_MAGIC;
            end else begin
              phase_nxt = PH_MINOR;
            end
          end
          PH_MINOR: begin tok.token_kind = TK_MINOR; phase_nxt = PH_MAJOR; end
          PH_MAJOR: begin tok.token_kind = TK_MAJOR; phase_nxt = PH_POOLCOUNT; end
          PH_POOLCOUNT: begin
            tok.token_kind = TK_POOLCOUNT;
            ptotal_nxt = v[15:0];
            pidx_nxt = '0;
            phase_nxt = (17'd1 < {1'b0, v[15:0]}) ? PH_TAG : PH_ACCESS;
          end
          PH_TAG: begin
            tok.token_kind = TK_TAG;
            tok.pool_slot = pi;
            if (!(v[7:0] == 8'd1 || (v[7:0] >= 8'd3 && v[7:0] <= 8'd12))) begin
              stop_nxt = 1'b1;
              tok.error_code = ERR_TAG;
            end else begin
              tag_nxt = v[3:0];
              opstep_nxt = '0;
              phase_nxt = (v[3:0] == TAG_UTF8) ? PH_UTF8LEN : PH_OPERAND;
            end
          end
          PH_OPERAND: begin
            tok.token_kind = wide ? TK_U4 : TK_U2;
            tok.pool_slot = pi;
            opstep_nxt = os + 2'd1;
            if ((os + 2'd1) >= ((dbl || (tg >= TAG_METHODREF_FIRST && tg <= TAG_NAMEANDTYPE))
                                ? 2'd2 : 2'd1)) begin
              pidx_nxt = pi_fin;
              phase_nxt = fin_ph;
            end
          end
          PH_UTF8LEN: begin
            tok.token_kind = TK_UTF8LEN;
            tok.pool_slot = pi;
            pay_nxt = v;
            if (v == 32'd0) begin
              pidx_nxt = pi_fin;
              phase_nxt = fin_ph;
            end else begin
              phase_nxt = PH_UTF8BYTE;
            end
          end
          PH_UTF8BYTE: begin
            tok.token_kind = TK_UTF8BYTE;
            tok.pool_slot = pi;
            pay_nxt = py_dec;
            if (py_dec == 32'd0) begin
              pidx_nxt = pi_fin;
              phase_nxt = fin_ph;
            end
          end
          PH_ACCESS: begin tok.token_kind = TK_ACCESS; phase_nxt = PH_THIS; end
          PH_THIS: begin tok.token_kind = TK_THIS; phase_nxt = PH_SUPER; end
          PH_SUPER: begin tok.token_kind = TK_SUPER; phase_nxt = PH_IFCOUNT; end
          PH_IFCOUNT: begin
            tok.token_kind = TK_IFCOUNT;
            items_nxt = v[15:0];
            phase_nxt = (v == 32'd0) ? PH_FIELDSCOUNT : PH_IFACE;
          end
          PH_IFACE: begin
            tok.token_kind = TK_IFACE;
            items_nxt = it_dec;
            if (it_dec == 16'd0) phase_nxt = PH_FIELDSCOUNT;
          end
          PH_FIELDSCOUNT, PH_METHODSCOUNT: begin
            tok.token_kind = (ph == PH_FIELDSCOUNT) ? TK_FIELDSCOUNT : TK_METHODSCOUNT;
            inmeth_nxt = (ph == PH_METHODSCOUNT);
            items_nxt = v[15:0];
            if (v == 32'd0)
              phase_nxt = (ph == PH_METHODSCOUNT) ? PH_CLASSATTRCOUNT : PH_METHODSCOUNT;
            else
              phase_nxt = PH_MACCESS;
          end
          PH_MACCESS: begin tok.token_kind = TK_MACCESS; phase_nxt = PH_MNAME; end
          PH_MNAME: begin tok.token_kind = TK_MNAME; phase_nxt = PH_MDESC; end
          PH_MDESC: begin tok.token_kind = TK_MDESC; phase_nxt = PH_MATTRCOUNT; end
          PH_MATTRCOUNT: begin
            tok.token_kind = TK_MATTRCOUNT;
            attrs_nxt = v[15:0];
            if (v != 32'd0) begin
              phase_nxt = PH_ATTRNAME;
            end else begin
              items_nxt = it_dec;
              phase_nxt = mdone_ph;
            end
          end
          PH_CLASSATTRCOUNT: begin
            tok.token_kind = TK_CLASSATTRCOUNT;
            attrs_nxt = v[15:0];
            phase_nxt = (v != 32'd0) ? PH_CANAME : PH_DONE;
          end
          PH_ATTRNAME: begin tok.token_kind = TK_ATTRNAME; phase_nxt = PH_ATTRLEN; end
          PH_CANAME: begin tok.token_kind = TK_ATTRNAME; phase_nxt = PH_CALEN; end
          PH_ATTRLEN, PH_CALEN, PH_ATTRBYTE, PH_CABYTE: begin
            if (ph == PH_ATTRLEN || ph == PH_CALEN) begin
              tok.token_kind = TK_ATTRLEN;
              pay_nxt = v;
            end else begin
              tok.token_kind = TK_ATTRBYTE;
              pay_nxt = py_dec;
            end
            if (ph == PH_ATTRLEN) phase_nxt = PH_ATTRBYTE;
            if (ph == PH_CALEN) phase_nxt = PH_CABYTE;
            if (pay_nxt == 32'd0) begin
              attrs_nxt = at_dec;
              if (at_dec != 16'd0) begin
                phase_nxt = (ph == PH_CALEN || ph == PH_CABYTE) ? PH_CANAME : PH_ATTRNAME;
              end else if (ph == PH_CALEN || ph == PH_CABYTE) begin
                phase_nxt = PH_DONE;
              end else begin
                items_nxt = it_dec;
                phase_nxt = mdone_ph;
              end
            end
          end
          default: begin tok.token_kind = TK_END; phase_nxt = PH_DONE; end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC; acc_r <= '0; nbytes_r <= '0; tag_r <= '0; opstep_r <= '0;
      ptotal_r <= '0; pidx_r <= '0; items_r <= '0; attrs_r <= '0; pay_r <= '0;
      inmeth_r <= 1'b0; stop_r <= 1'b0; vld_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; acc_r <= acc_nxt; nbytes_r <= nbytes_nxt; tag_r <= tag_nxt;
        opstep_r <= opstep_nxt; ptotal_r <= ptotal_nxt; pidx_r <= pidx_nxt;
        items_r <= items_nxt; attrs_r <= attrs_nxt; pay_r <= pay_nxt;
        inmeth_r <= inmeth_nxt; stop_r <= stop_nxt;
        vld_r <= emit;
      end else if (res_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) res_r <= tok;
  end

endmodule
`default_nettype wire

[sv/class_file_stream_parser.sv]
// Top level of the class file stream parser.
// Takes one class file byte per transaction and gives at most one token per byte, in the
// next cycle from a result register; a new byte is taken in every cycle while the result
// side keeps up. The parse state is updated as each byte is taken, which sets this rate.
`default_nettype none
module class_file_stream_parser
  import cfsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  cfsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_valid),
    .item      (in_data),
    .item_ready(in_ready),
    .res_valid (out_valid),
    .res       (out_data),
    .res_ready (out_ready)
  );

endmodule
`default_nettype wire
